[rtl/tmf_pkg.sv]
// Shared constants, register indexes and sequencer states for the TDS median filter.
`default_nettype none
package tmf_pkg;

  localparam int SAMPLE_COUNT_DEF = 32;

  localparam int ADC_W  = 12;
  localparam int VREF_W = 13;
  localparam int TEMP_W = 11;
  localparam int INTV_W = 10;
  localparam int PPM_W  = 11;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_VREF = 2'd0;
  localparam logic [1:0] REG_TEMP = 2'd1;
  localparam logic [1:0] REG_INTV = 2'd2;

  localparam logic [VREF_W-1:0] VREF_RST = 13'd3300;
  localparam logic [TEMP_W-1:0] TEMP_RST = 11'd250;
  localparam logic [INTV_W-1:0] INTV_RST = 10'd20;

  // polynomial coefficients, Q16
  localparam logic [25:0] COEF_A = 26'd8743813;
  localparam logic [25:0] COEF_B = 26'd16768041;
  localparam logic [25:0] COEF_C = 26'd56189911;

  // ceil(2^33 / 125): median*vref*2/125 == (median*vref*VOLT_RECIP) >> 32 for all inputs
  localparam logic [26:0] VOLT_RECIP = 27'd68719477;
  localparam logic [25:0] COMP_MUL  = 26'd500;
  localparam logic [18:0] VOLT_MAX  = 19'd524287;
  localparam logic [27:0] COMP_MAX  = 28'd524288;
  localparam logic [35:0] POLY_MAX  = 36'd131072000;  // 2000 in Q16
  localparam logic [11:0] DENOM_OFS = 12'd250;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_CAND,
    S_LD_CAND,
    S_SCAN,
    S_SCAN_END,
    S_EVAL,
    S_MED,
    S_M_VREF,
    S_LD_V,
    S_SAT,
    S_LD_C,
    S_DIV_C,
    S_CHK,
    S_SQ,
    S_CU,
    S_TA,
    S_TB,
    S_TC,
    S_SUM,
    S_FIN,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

[rtl/tds_median_filter_converter.sv]
// TDS sensor block: sample ring in memory, rank-count median, fixed-point cubic conversion.
//
//  channel | dir | ports                                   | beat
//  in_     | in  | tvalid tready tdata[15:0]               | one converter sample
//  out_    | out | tvalid tready tdata[15:0] tuser         | one TDS result
//  cfg_    | in  | psel penable pwrite paddr pwdata prdata | one register access
//
// A sample that gives no result leaves the block idle. For a sample that gives a result,
// the median is found by rank counting, N candidates each swept over the ring through
// its single read port, then a 28-step serial divider applies the temperature coefficient
// and a shared multiplier forms every product (the scale to volts is a reciprocal multiply).
// Reset clears the ring through per-entry valid bits at once; no clearing pass.
// A finished result waits in the output register while the block returns to idle and takes samples.
`default_nettype none
module tds_median_filter_converter
  import tmf_pkg::*;
#(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,     // [11:0] adc_sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,    // [10:0] tds_ppm
  output logic             out_tuser,    // [0] out_of_range
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int IW     = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int CW     = $clog2(SAMPLE_COUNT + 1);
  localparam int K_LO   = (SAMPLE_COUNT - 1) / 2;
  localparam int K_HI   = SAMPLE_COUNT / 2;
  localparam logic [IW-1:0] LAST = IW'(SAMPLE_COUNT - 1);

  // ring memory
  logic [ADC_W-1:0] mem [SAMPLE_COUNT];
  logic [ADC_W-1:0] rd_data_r;
  logic             rd_ok_r;
  logic [IW-1:0]    rd_addr;
  logic [ADC_W-1:0] rdv;

  state_t state_r, state_nxt;
  logic [VREF_W-1:0]       vref_r, vref_nxt;
  logic [TEMP_W-1:0]       temp_r, temp_nxt;
  logic [INTV_W-1:0]       intv_r, intv_nxt;
  logic [IW-1:0]           wp_r, wp_nxt;
  logic [INTV_W-1:0]       sud_r, sud_nxt;
  logic [SAMPLE_COUNT-1:0] valid_r, valid_nxt;
  logic [IW-1:0]           cand_r, cand_nxt;
  logic [IW-1:0]           scan_r, scan_nxt;
  logic                    cmp_v_r, cmp_v_nxt;
  logic [4:0]              dcnt_r, dcnt_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // payload
  logic [ADC_W-1:0]  cand_val_r, cand_val_nxt;
  logic [CW-1:0]     lt_r, lt_nxt, le_r, le_nxt;
  logic [ADC_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [ADC_W-1:0]  med_r, med_nxt;
  logic [51:0]       prod_r;
  logic [27:0]       dq_r, dq_nxt;
  logic [10:0]       rem_r, rem_nxt, dv_r, dv_nxt;
  logic [19:0]       comp_r, comp_nxt;
  logic [22:0]       c2_r, c2_nxt;
  logic signed [52:0] acc_r, acc_nxt;
  logic              oor_r, oor_nxt;
  logic [PPM_W-1:0]  ppm_r, ppm_nxt;
  logic [PPM_W-1:0]  out_ppm_r, out_ppm_nxt;
  logic              out_oor_r, out_oor_nxt;

  logic [26:0] mul_a;
  logic [25:0] mul_b;
  logic [51:0] mul_p;
  logic        in_acc, cfg_wr, we;
  logic [11:0] rem_sh;
  logic        ge;
  logic signed [11:0] denom_s;
  logic [12:0] med_sum;
  logic [35:0] poly;

  assign in_acc     = in_tvalid && in_tready;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign we         = in_acc;
  assign cfg_pready = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_ppm_r};
  assign out_tuser  = out_oor_r;

  assign rdv     = rd_ok_r ? rd_data_r : '0;
  assign rd_addr = (state_r == S_RD_CAND) ? cand_r : scan_r;

  assign rem_sh  = {rem_r, dq_r[27]};
  assign ge      = rem_sh >= {1'b0, dv_r};
  assign denom_s = $signed({temp_r[TEMP_W-1], temp_r}) + $signed(DENOM_OFS);
  assign med_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign poly    = acc_r[52:17];
  // every product used fits in 52 bits
  assign mul_p   = {25'd0, mul_a} * {26'd0, mul_b};

  always_comb begin
    case (cfg_paddr[3:2])
      REG_VREF: cfg_prdata = {19'd0, vref_r};
      REG_TEMP: cfg_prdata = {{21{temp_r[TEMP_W-1]}}, temp_r};
      REG_INTV: cfg_prdata = {22'd0, intv_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_M_VREF: begin
        mul_a = 27'(med_r);
        mul_b = 26'(vref_r);
      end
      S_LD_V: begin
        // median*vref < 2^25
        mul_a = VOLT_RECIP;
        mul_b = 26'(prod_r[24:0]);
      end
      S_SAT: begin
        mul_a = prod_r[51] ? 27'(VOLT_MAX) : 27'(prod_r[50:32]);
        mul_b = COMP_MUL;
      end
      S_SQ: begin
        mul_a = 27'(comp_r);
        mul_b = 26'(comp_r);
      end
      S_CU: begin
        mul_a = 27'(prod_r[38:16]);
        mul_b = 26'(comp_r);
      end
      S_TA: begin
        mul_a = 27'(COEF_A);
        mul_b = prod_r[41:16];
      end
      S_TB: begin
        mul_a = 27'(COEF_B);
        mul_b = 26'(c2_r);
      end
      S_TC: begin
        mul_a = 27'(COEF_C);
        mul_b = 26'(comp_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    vref_nxt      = vref_r;
    temp_nxt      = temp_r;
    intv_nxt      = intv_r;
    wp_nxt        = wp_r;
    sud_nxt       = sud_r;
    valid_nxt     = valid_r;
    cand_nxt      = cand_r;
    scan_nxt      = scan_r;
    cmp_v_nxt     = cmp_v_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r;
    cand_val_nxt  = cand_val_r;
    lt_nxt        = lt_r;
    le_nxt        = le_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    med_nxt       = med_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    dv_nxt        = dv_r;
    comp_nxt      = comp_r;
    c2_nxt        = c2_r;
    acc_nxt       = acc_r;
    oor_nxt       = oor_r;
    ppm_nxt       = ppm_r;
    out_ppm_nxt   = out_ppm_r;
    out_oor_nxt   = out_oor_r;

    if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_VREF: vref_nxt = cfg_pwdata[VREF_W-1:0];
        REG_TEMP: temp_nxt = cfg_pwdata[TEMP_W-1:0];
        REG_INTV: intv_nxt = cfg_pwdata[INTV_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          valid_nxt[wp_r] = 1'b1;
          wp_nxt = (wp_r == LAST) ? '0 : wp_r + 1'b1;
          if (sud_r > INTV_W'(1)) begin
            sud_nxt = sud_r - 1'b1;
          end else begin
            sud_nxt   = (intv_r == '0) ? INTV_W'(1) : intv_r;
            cand_nxt  = '0;
            state_nxt = S_RD_CAND;
          end
        end
      end
      S_RD_CAND: state_nxt = S_LD_CAND;
      S_LD_CAND: begin
        cand_val_nxt = rdv;
        scan_nxt     = '0;
        cmp_v_nxt    = 1'b0;
        lt_nxt       = '0;
        le_nxt       = '0;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        // read data is registered, so it lags its address
        cmp_v_nxt = 1'b1;
        if (cmp_v_r) begin
          if (rdv < cand_val_r)  lt_nxt = lt_r + 1'b1;
          if (rdv <= cand_val_r) le_nxt = le_r + 1'b1;
        end
        if (scan_r == LAST) state_nxt = S_SCAN_END;
        else scan_nxt = scan_r + 1'b1;
      end
      S_SCAN_END: begin
        if (rdv < cand_val_r)  lt_nxt = lt_r + 1'b1;
        if (rdv <= cand_val_r) le_nxt = le_r + 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // candidate holds sorted positions lt .. le-1
        if (lt_r <= CW'(K_LO) && CW'(K_LO) < le_r) lo_nxt = cand_val_r;
        if (lt_r <= CW'(K_HI) && CW'(K_HI) < le_r) hi_nxt = cand_val_r;
        if (cand_r == LAST) begin
          state_nxt = S_MED;
        end else begin
          cand_nxt  = cand_r + 1'b1;
          state_nxt = S_RD_CAND;
        end
      end
      S_MED: begin
        med_nxt   = med_sum[12:1];
        oor_nxt   = 1'b0;
        ppm_nxt   = '0;
        state_nxt = S_M_VREF;
      end
      S_M_VREF: state_nxt = S_LD_V;
      S_LD_V: state_nxt = S_SAT;
      S_DIV_C: begin
        dq_nxt   = {dq_r[26:0], ge};
        rem_nxt  = ge ? 11'(rem_sh - {1'b0, dv_r}) : rem_sh[10:0];
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 5'd27) state_nxt = S_CHK;
      end
      S_SAT: begin
        if (denom_s <= 12'sd0) begin
          oor_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_LD_C;
        end
      end
      S_LD_C: begin
        dq_nxt    = prod_r[27:0];
        rem_nxt   = '0;
        dv_nxt    = denom_s[10:0];
        dcnt_nxt  = '0;
        state_nxt = S_DIV_C;
      end
      S_CHK: begin
        if (dq_r > COMP_MAX) begin
          oor_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          comp_nxt  = dq_r[19:0];
          state_nxt = S_SQ;
        end
      end
      S_SQ: state_nxt = S_CU;
      S_CU: begin
        c2_nxt    = prod_r[38:16];
        state_nxt = S_TA;
      end
      S_TA: state_nxt = S_TB;
      S_TB: begin
        acc_nxt   = $signed({1'b0, prod_r});
        state_nxt = S_TC;
      end
      S_TC: begin
        acc_nxt   = acc_r - $signed({1'b0, prod_r});
        state_nxt = S_SUM;
      end
      S_SUM: begin
        acc_nxt   = acc_r + $signed({1'b0, prod_r});
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (acc_r < 0 || poly > POLY_MAX) oor_nxt = 1'b1;
        else ppm_nxt = poly[26:16];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ppm_nxt   = oor_r ? '0 : ppm_r;
          out_oor_nxt   = oor_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vref_r      <= VREF_RST;
      temp_r      <= TEMP_RST;
      intv_r      <= INTV_RST;
      wp_r        <= '0;
      sud_r       <= INTV_RST;
      valid_r     <= '0;
      cand_r      <= '0;
      scan_r      <= '0;
      cmp_v_r     <= 1'b0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vref_r      <= vref_nxt;
      temp_r      <= temp_nxt;
      intv_r      <= intv_nxt;
      wp_r        <= wp_nxt;
      sud_r       <= sud_nxt;
      valid_r     <= valid_nxt;
      cand_r      <= cand_nxt;
      scan_r      <= scan_nxt;
      cmp_v_r     <= cmp_v_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_val_r <= cand_val_nxt;
    lt_r       <= lt_nxt;
    le_r       <= le_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    med_r      <= med_nxt;
    prod_r     <= mul_p;
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    dv_r       <= dv_nxt;
    comp_r     <= comp_nxt;
    c2_r       <= c2_nxt;
    acc_r      <= acc_nxt;
    oor_r      <= oor_nxt;
    ppm_r      <= ppm_nxt;
    out_ppm_r  <= out_ppm_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wp_r] <= in_tdata[ADC_W-1:0];
    rd_data_r <= mem[rd_addr];
    rd_ok_r   <= valid_r[rd_addr];
  end

  a_no_result_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && sud_r > INTV_W'(1) |=> state_r == S_IDLE)
    else $error("sample without result left idle");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 16'd0)
    else $error("out of range result with nonzero ppm");

  a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && (!out_valid_r || out_tready) |=> out_tvalid && state_r == S_IDLE)
    else $error("finished result not presented");

endmodule
`default_nettype wire

[bench/tmf_checker.sv]
// TDS median filter checker: snoops all but cfg_prdata; predicts and compares results.
`timescale 1ns / 1ps
module tmf_checker
  import tmf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [15:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,
  input  wire logic        out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               mismatches,
  output int               pending,
  output int               samples_seen,
  output int               results_seen
);

  localparam int RING_N = 32;
  localparam longint K_CUBE = 64'd8743813;
  localparam longint K_SQUARE = 64'd16768041;
  localparam longint K_LINEAR = 64'd56189911;

  typedef struct packed {
    logic [PPM_W-1:0] ppm;
    logic             oor;
  } tds_result_t;

  tds_result_t          tds_expected_q[$];
  logic [ADC_W-1:0]     ring[RING_N];
  int                   wr_pos;
  int                   countdown;
  logic [VREF_W-1:0]    vref_mv;
  logic signed [TEMP_W-1:0] temp_tenths;
  logic [INTV_W-1:0]    interval;

  function automatic longint ring_median();
    longint s[RING_N];
    longint t;
    for (int i = 0; i < RING_N; i++) s[i] = ring[i];
    for (int i = 0; i < RING_N - 1; i++)
      for (int j = 0; j < RING_N - 1 - i; j++)
        if (s[j] > s[j+1]) begin
          t = s[j]; s[j] = s[j+1]; s[j+1] = t;
        end
    if (RING_N % 2 == 1) return s[(RING_N-1)/2];
    return (s[RING_N/2] + s[RING_N/2-1]) / 2;
  endfunction

  function automatic tds_result_t tds_from_median(longint med);
    tds_result_t r;
    longint volts, denom, comp, c2, c3, sum, poly;
    r.ppm = '0;
    r.oor = 1'b1;
    volts = med * longint'(vref_mv) * 65536 / 4096000;
    if (volts > 524287) volts = 524287;
    denom = longint'(temp_tenths) + 250;
    if (denom <= 0) return r;
    comp = volts * 500 / denom;
    if (comp > 524288) return r;
    c2 = comp * comp / 65536;
    c3 = c2 * comp / 65536;
    sum = K_CUBE * c3 - K_SQUARE * c2 + K_LINEAR * comp;
    if (sum < 0) return r;
    poly = sum / 131072;
    if (poly > 64'd131072000) return r;
    r.ppm = PPM_W'(poly / 65536);
    r.oor = 1'b0;
    return r;
  endfunction

  assign pending = tds_expected_q.size();

  always @(posedge clk) begin
    tds_result_t got;
    tds_result_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < RING_N; i++) ring[i] = '0;
      wr_pos       <= 0;
      countdown    <= 20;
      vref_mv      <= VREF_RST;
      temp_tenths  <= TEMP_RST;
      interval     <= INTV_RST;
      mismatches   <= 0;
      samples_seen <= 0;
      results_seen <= 0;
      tds_expected_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_VREF: vref_mv     <= cfg_pwdata[VREF_W-1:0];
          REG_TEMP: temp_tenths <= cfg_pwdata[TEMP_W-1:0];
          REG_INTV: interval    <= cfg_pwdata[INTV_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        // blocking write so the median sees the new sample
        ring[wr_pos] = in_tdata[ADC_W-1:0];
        wr_pos <= (wr_pos + 1) % RING_N;
        samples_seen <= samples_seen + 1;
        if (countdown > 1) begin
          countdown <= countdown - 1;
        end else begin
          countdown <= (interval == 0) ? 1 : interval;
          tds_expected_q.push_back(tds_from_median(ring_median()));
        end
      end
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        got.ppm = out_tdata[PPM_W-1:0];
        got.oor = out_tuser;
        if (tds_expected_q.size() == 0) begin
          $error("unexpected result beat: tds_ppm %0d out_of_range %0d", got.ppm, got.oor);
          errs++;
        end else begin
          want = tds_expected_q.pop_front();
          if (got.ppm !== want.ppm) begin
            $error("tds_ppm: expected %0d, got %0d", want.ppm, got.ppm);
            errs++;
          end
          if (got.oor !== want.oor) begin
            $error("out_of_range: expected %0d, got %0d", want.oor, got.oor);
            errs++;
          end
        end
      end
      if (errs != 0) mismatches <= mismatches + errs;
    end
  end

endmodule

[bench/tb_tds_median_filter_converter.sv]
// Testbench top: clock, reset, sample and register stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps
module tb_tds_median_filter_converter;
  import tmf_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int  mismatches, pending, samples_seen, results_seen;
  int  cycles = 0;
  bit  steady = 0;      // no idling on either side
  bit  long_hold = 0;   // receiver does one long stall
  int  base;

  tds_median_filter_converter uut (.*);

  tmf_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_pready, .mismatches, .pending, .samples_seen, .results_seen
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result receiver
  initial begin
    int n;
    bit held;
    held = 0;
    forever begin
      if (long_hold && !held) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (5000) @(posedge clk);
      end
      n = steady ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_sample(input logic [ADC_W-1:0] v);
    int n;
    n = steady ? 0 : $urandom_range(0, 6);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, v};
    do @(posedge clk); while (!in_tready);
  endtask

  // drop valid and wait until every predicted result has drained
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [ADC_W-1:0] near_base();
    int v;
    if ($urandom_range(0, 7) == 0) return ADC_W'($urandom_range(0, 4095));
    v = base + $urandom_range(0, 400) - 200;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return ADC_W'(v);
  endfunction

  initial begin
    logic signed [TEMP_W-1:0] t;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: one result after 20 samples, extremes and alternating bits
    for (int i = 0; i < 20; i++)
      send_sample((i % 4 == 0) ? 12'hFFF : (i % 4 == 1) ? 12'h000 :
                  (i % 4 == 2) ? 12'hAAA : 12'h555);
    drain();

    // zero interval (acts as one from the next reload) and the widest reference; these samples give no result
    reg_write(REG_INTV, 32'd0);
    reg_write(REG_VREF, 32'd8191);
    reg_write(REG_TEMP, 32'(TEMP_W'(-1024)));
    send_sample(12'hFFF);
    drain();
    reg_write(REG_TEMP, 32'(TEMP_W'(-250)));   // coefficient exactly zero
    send_sample(12'hFFF);
    drain();
    reg_write(REG_TEMP, 32'(TEMP_W'(-240)));   // tiny coefficient
    send_sample(12'h800);
    drain();
    reg_write(REG_TEMP, 32'(TEMP_W'(1023)));
    reg_write(REG_VREF, 32'd0);
    send_sample(12'hFFF);
    drain();
    reg_write(REG_VREF, 32'd5500);
    reg_write(REG_TEMP, 32'(TEMP_W'(250)));
    for (int i = 0; i < 4; i++) send_sample(12'h3FF);
    drain();

    // interval change lands at the next reload
    reg_write(REG_INTV, 32'd3);
    send_sample(12'h100);
    send_sample(12'hC00);
    drain();
    reg_write(REG_INTV, 32'd1023);
    send_sample(12'h000);
    drain();

    // random phases of clustered samples with some noise
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 5))
        0: reg_write(REG_VREF, 32'd8191);
        1: reg_write(REG_VREF, 32'd1000);
        default: reg_write(REG_VREF, 32'($urandom_range(1000, 5500)));
      endcase
      case ($urandom_range(0, 6))
        0: t = TEMP_W'(-1024);
        1: t = TEMP_W'(1023);
        2: t = TEMP_W'(-100);
        default: t = TEMP_W'($urandom_range(0, 1100) - 100);
      endcase
      reg_write(REG_TEMP, 32'(t));
      case ($urandom_range(0, 9))
        0: reg_write(REG_INTV, 32'd0);
        1: reg_write(REG_INTV, 32'd1000);
        default: reg_write(REG_INTV, 32'($urandom_range(1, 8)));
      endcase
      if (ph == 2) reg_write(REG_INTV, 32'd1);
      steady = (ph == 4);
      if (ph == 2) long_hold = 1;
      base = $urandom_range(0, 4095);
      for (int i = 0; i < 34; i++) send_sample(near_base());
      drain();
    end

    repeat (200) @(posedge clk);
    $display("Covered %0d samples and %0d results over several register settings,",
             samples_seen, results_seen);
    $display("including saturation, non-positive coefficient and out-of-range cases.");
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tmf_pkg.sv
rtl/tds_median_filter_converter.sv
bench/tmf_checker.sv
bench/tb_tds_median_filter_converter.sv
